// File: design/srec_pkg.sv
// package: shared types, constants and helpers of the s-record line checker
package srec_pkg;

  localparam int MAX_RECORD_BYTES_DEF = 64;

  localparam int POS_W   = 10;
  localparam int ADDR_W  = 24;
  localparam int LINES_W = 16;

  localparam logic [7:0]         CHAR_S     = 8'h53;
  localparam logic [7:0]         SUM_OK     = 8'hFF;
  localparam logic [POS_W-1:0]   POS_HOLD_A = 10'd1022;
  localparam logic [POS_W-1:0]   POS_HOLD_B = 10'd1023;
  localparam logic [POS_W-1:0]   LEN_MIN    = 10'd6;
  localparam logic [POS_W-1:0]   LEN_MIN_S0 = 10'd10;
  localparam logic [LINES_W-1:0] LINES_MAX  = 16'hFFFF;

  // record type digits
  localparam logic [3:0] RT_HEADER = 4'h0;
  localparam logic [3:0] RT_DATA16 = 4'h1;
  localparam logic [3:0] RT_DATA24 = 4'h2;
  localparam logic [3:0] RT_COUNT  = 4'h5;
  localparam logic [3:0] RT_END24  = 4'h8;
  localparam logic [3:0] RT_END16  = 4'h9;

  // seen-kind flag bits
  localparam int KIND_HEADER = 0;
  localparam int KIND_DATA   = 1;
  localparam int KIND_COUNT  = 2;
  localparam int KIND_END    = 3;

  // register index, taken from paddr bit 2
  localparam logic REG_MIN_ADDRESS    = 1'b0;
  localparam logic REG_REQUIRED_TYPES = 1'b1;
  localparam logic [3:0] REQ_TYPES_RESET = 4'd11;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NO_S      = 4'd1,
    ST_SHORT     = 4'd2,
    ST_ODD       = 4'd3,
    ST_BAD_HEX   = 4'd4,
    ST_COUNT     = 4'd5,
    ST_CHECKSUM  = 4'd6,
    ST_BAD_S0    = 4'd7,
    ST_TOO_LONG  = 4'd8,
    ST_BAD_TYPE  = 4'd9
  } status_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [3:0]         record_type;
    logic [ADDR_W-1:0]  record_address;
    logic [7:0]         data_bytes;
    logic               in_window;
    logic [LINES_W-1:0] data_lines;
    logic [3:0]         types_seen;
    logic               file_complete;
  } line_result_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
    logic       file_start;
  } char_item_t;

  // bit 4 flags a valid hex digit, low nibble is its value (zero if invalid)
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: design/srec_if.sv
// interfaces: character item channel and line result channel
interface srec_in_if;
  import srec_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;
  logic       file_start;

  modport source (output valid, output char_code, output line_end, output file_start,
                  input ready);
  modport sink (input valid, input char_code, input line_end, input file_start,
                output ready);
endinterface

interface srec_out_if;
  import srec_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [3:0]         record_type;
  logic [ADDR_W-1:0]  record_address;
  logic [7:0]         data_bytes;
  logic               in_window;
  logic [LINES_W-1:0] data_lines;
  logic [3:0]         types_seen;
  logic               file_complete;

  modport source (output valid, output status, output record_type, output record_address,
                  output data_bytes, output in_window, output data_lines,
                  output types_seen, output file_complete, input ready);
  modport sink (input valid, input status, input record_type, input record_address,
                input data_bytes, input in_window, input data_lines,
                input types_seen, input file_complete, output ready);
endinterface

// File: design/srec_chk_core.sv
// line state, per-character update and end-of-line checks
module srec_chk_core
  import srec_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  char_item_t        item,
  input  logic [ADDR_W-1:0] min_address,
  input  logic [3:0]        required_types,
  output line_result_t      result
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [3:0]         upper_r, upper_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [3:0]         type_r, type_nxt;
  logic               start_bad_r, start_bad_nxt;
  logic               hex_bad_r, hex_bad_nxt;
  logic [3:0]         seen_r, seen_nxt;
  logic [LINES_W-1:0] lines_r, lines_nxt;

  logic [POS_W-1:0]   cur_pos, k;
  logic [4:0]         hx;
  logic [7:0]         b;
  logic [POS_W:0]     len_expect;
  logic [POS_W-1:0]   len_half;
  logic [7:0]         over;

  always_comb begin
    cur_pos       = item.file_start ? '0 : pos_r;
    upper_nxt     = item.file_start ? '0 : upper_r;
    sum_nxt       = item.file_start ? '0 : sum_r;
    count_nxt     = item.file_start ? '0 : count_r;
    addr_nxt      = item.file_start ? '0 : addr_r;
    type_nxt      = item.file_start ? '0 : type_r;
    start_bad_nxt = item.file_start ? 1'b0 : start_bad_r;
    hex_bad_nxt   = item.file_start ? 1'b0 : hex_bad_r;
    seen_nxt      = item.file_start ? '0 : seen_r;
    lines_nxt     = item.file_start ? '0 : lines_r;

    hx = hex_decode(item.char_code);
    b  = {upper_nxt, hx[3:0]};
    k  = (cur_pos - POS_W'(3)) >> 1;

    if (cur_pos == '0) begin
      if (item.char_code != CHAR_S) begin
        start_bad_nxt = 1'b1;
      end
    end else begin
      if (!hx[4]) begin
        hex_bad_nxt = 1'b1;
      end
      if (cur_pos == POS_W'(1)) begin
        type_nxt = hx[3:0];
      end else if (!cur_pos[0]) begin
        upper_nxt = hx[3:0];
      end else begin
        sum_nxt = sum_nxt + b;
        if (k == '0) begin
          count_nxt = b;
        end else if (type_nxt == RT_DATA16) begin
          if (k == POS_W'(1)) addr_nxt[15:8] = addr_nxt[15:8] | b;
          if (k == POS_W'(2)) addr_nxt[7:0]  = addr_nxt[7:0] | b;
        end else if (type_nxt == RT_DATA24) begin
          if (k == POS_W'(1)) addr_nxt[23:16] = addr_nxt[23:16] | b;
          if (k == POS_W'(2)) addr_nxt[15:8]  = addr_nxt[15:8] | b;
          if (k == POS_W'(3)) addr_nxt[7:0]   = addr_nxt[7:0] | b;
        end
      end
    end

    // saturate, alternating so parity stays right
    if (cur_pos < POS_HOLD_A) begin
      pos_nxt = cur_pos + POS_W'(1);
    end else if (cur_pos == POS_HOLD_A) begin
      pos_nxt = POS_HOLD_B;
    end else begin
      pos_nxt = POS_HOLD_A;
    end

    len_expect = (POS_W+1)'({count_nxt, 1'b0}) + (POS_W+1)'(4);
    len_half   = (pos_nxt - POS_W'(2)) >> 1;
    over       = (type_nxt == RT_DATA16) ? 8'd3 : 8'd4;

    result                = '0;
    result.record_type    = type_nxt;
    priority if (start_bad_nxt) begin
      result.status = ST_NO_S;
    end else if (pos_nxt < LEN_MIN) begin
      result.status = ST_SHORT;
    end else if (pos_nxt[0]) begin
      result.status = ST_ODD;
    end else if (hex_bad_nxt) begin
      result.status = ST_BAD_HEX;
    end else if ({1'b0, pos_nxt} != len_expect) begin
      result.status = ST_COUNT;
    end else if (sum_nxt != SUM_OK) begin
      result.status = ST_CHECKSUM;
    end else begin
      unique case (type_nxt)
        RT_HEADER: begin
          if (pos_nxt < LEN_MIN_S0) begin
            result.status = ST_BAD_S0;
          end else begin
            result.status = ST_OK;
            seen_nxt[KIND_HEADER] = 1'b1;
          end
        end
        RT_DATA16, RT_DATA24: begin
          if (len_half > POS_W'(MAX_RECORD_BYTES)) begin
            result.status = ST_TOO_LONG;
          end else begin
            result.status         = ST_OK;
            result.record_address = addr_nxt;
            result.data_bytes     = (count_nxt > over) ? (count_nxt - over) : 8'd0;
            result.in_window      = (addr_nxt >= min_address);
            if (lines_nxt != LINES_MAX) begin
              lines_nxt = lines_nxt + LINES_W'(1);
            end
            seen_nxt[KIND_DATA] = 1'b1;
          end
        end
        RT_COUNT: begin
          result.status = ST_OK;
          seen_nxt[KIND_COUNT] = 1'b1;
        end
        RT_END24, RT_END16: begin
          result.status = ST_OK;
          seen_nxt[KIND_END] = 1'b1;
        end
        default: begin
          result.status = ST_BAD_TYPE;
        end
      endcase
    end
    result.data_lines    = lines_nxt;
    result.types_seen    = seen_nxt;
    result.file_complete = ((seen_nxt & required_types) == required_types);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      upper_r     <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      type_r      <= '0;
      start_bad_r <= 1'b0;
      hex_bad_r   <= 1'b0;
      seen_r      <= '0;
      lines_r     <= '0;
    end else if (step_en) begin
      if (item.line_end) begin
        seen_r      <= seen_nxt;
        lines_r     <= lines_nxt;
        pos_r       <= '0;
        upper_r     <= '0;
        sum_r       <= '0;
        count_r     <= '0;
        addr_r      <= '0;
        type_r      <= '0;
        start_bad_r <= 1'b0;
        hex_bad_r   <= 1'b0;
      end else begin
        if (item.file_start) begin
          seen_r  <= '0;
          lines_r <= '0;
        end
        pos_r       <= pos_nxt;
        upper_r     <= upper_nxt;
        sum_r       <= sum_nxt;
        count_r     <= count_nxt;
        addr_r      <= addr_nxt;
        type_r      <= type_nxt;
        start_bad_r <= start_bad_nxt;
        hex_bad_r   <= hex_bad_nxt;
      end
    end
  end

endmodule

// File: design/srec_line_checker_unit.sv
// top level: s-record line checker with item channels and register port
// Checks Motorola S-record lines fed one character per item (CR/LF removed,
// line_end on the last character). Each item goes through an input register,
// then the line state update and checks, and a line's result lands in an output
// register; unless the input stalls, the block takes one character every cycle.
// While a finished result waits to be taken, characters inside a line still
// move on, and the input stalls only once the next line's last character sits
// in the input register.
// Registers: min_address at 0x0, required_types at 0x4 (reset 11); write them
// only while the block is idle.
module srec_line_checker_unit
  import srec_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  srec_in_if.sink       in_ch,
  srec_out_if.source    out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic [ADDR_W-1:0] min_addr_r;
  logic [3:0]        req_types_r;
  logic              cfg_wr;

  logic              s1_v_r;
  char_item_t        s1_item_r;
  logic              out_v_r;
  line_result_t      out_res_r;
  line_result_t      core_res;
  logic              out_free, s1_go, in_acc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_REQUIRED_TYPES) ? {28'd0, req_types_r}
                                                           : {8'd0, min_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_addr_r  <= '0;
      req_types_r <= REQ_TYPES_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MIN_ADDRESS) begin
        min_addr_r <= cfg_pwdata[ADDR_W-1:0];
      end else begin
        req_types_r <= cfg_pwdata[3:0];
      end
    end
  end

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_go       = s1_v_r && (!s1_item_r.line_end || out_free);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && s1_item_r.line_end) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.char_code  <= in_ch.char_code;
      s1_item_r.line_end   <= in_ch.line_end;
      s1_item_r.file_start <= in_ch.file_start;
    end
    if (s1_go && s1_item_r.line_end) begin
      out_res_r <= core_res;
    end
  end

  srec_chk_core #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (s1_go),
    .item           (s1_item_r),
    .min_address    (min_addr_r),
    .required_types (req_types_r),
    .result         (core_res)
  );

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.record_type    = out_res_r.record_type;
  assign out_ch.record_address = out_res_r.record_address;
  assign out_ch.data_bytes     = out_res_r.data_bytes;
  assign out_ch.in_window      = out_res_r.in_window;
  assign out_ch.data_lines     = out_res_r.data_lines;
  assign out_ch.types_seen     = out_res_r.types_seen;
  assign out_ch.file_complete  = out_res_r.file_complete;

`ifndef SYNTHESIS
  a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.status != ST_OK) |->
      (out_res_r.record_address == '0) && (out_res_r.data_bytes == '0) &&
      !out_res_r.in_window)
    else $error("failed line carries address or data count");

  a_window_data_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.in_window |->
      (out_res_r.record_type == RT_DATA16) || (out_res_r.record_type == RT_DATA24))
    else $error("in_window set on a non-data record");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_res_r))
    else $error("pending result lost or changed");

  a_no_result_midline: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r && s1_go && !s1_item_r.line_end |=> !out_v_r)
    else $error("result produced without end of line");
`endif

endmodule

// File: tb/srec_result_checker.sv
// line result checker: predicts each line result from accepted characters and compares
`timescale 1ns / 100ps

module srec_result_checker
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  srec_in_if          in_mon,
  srec_out_if         out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          pending_lines
);

  logic [POS_W-1:0]   pos_q;
  logic [3:0]         hi_nib_q;
  logic [7:0]         sum_q;
  logic [7:0]         count_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [3:0]         type_q;
  logic               no_s_q;
  logic               bad_hex_q;
  logic [3:0]         kinds_q;
  logic [LINES_W-1:0] lines_q;
  logic [ADDR_W-1:0]  window_base;
  logic [3:0]         needed_kinds;
  line_result_t       line_q[$];

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void clear_line();
    pos_q     = '0;
    hi_nib_q  = '0;
    sum_q     = '0;
    count_q   = '0;
    addr_q    = '0;
    type_q    = '0;
    no_s_q    = 1'b0;
    bad_hex_q = 1'b0;
  endfunction

  // returns 1 when the character closes a line, with the line result in res
  function automatic bit take_char(input logic [7:0] c, input logic last, input logic fs,
                                   output line_result_t res);
    logic [POS_W-1:0]  at;
    int                hv;
    logic [3:0]        nib;
    logic [7:0]        b;
    int                k;
    int                len;
    int                over;
    status_t           st;
    logic [ADDR_W-1:0] rec_addr;
    logic [7:0]        dbytes;
    logic              win;
    res = '0;
    if (fs) begin
      kinds_q = '0;
      lines_q = '0;
      clear_line();
    end
    at  = pos_q;
    hv  = nibble_of(c);
    nib = (hv < 0) ? 4'd0 : 4'(hv);
    if (at == '0) begin
      if (c != CHAR_S) no_s_q = 1'b1;
    end else begin
      if (hv < 0) bad_hex_q = 1'b1;
      if (at == POS_W'(1)) begin
        type_q = nib;
      end else if (!at[0]) begin
        hi_nib_q = nib;
      end else begin
        b = {hi_nib_q, nib};
        k = (int'(at) - 3) / 2;
        sum_q = sum_q + b;
        if (k == 0) begin
          count_q = b;
        end else if (k <= 3) begin
          if (type_q == RT_DATA16 && k <= 2) addr_q = addr_q | (ADDR_W'(b) << ((2 - k) * 8));
          else if (type_q == RT_DATA24) addr_q = addr_q | (ADDR_W'(b) << ((3 - k) * 8));
        end
      end
    end
    // saturating position keeps its parity by toggling between the two top values
    if (at < POS_HOLD_A) pos_q = at + 1'b1;
    else pos_q = (at == POS_HOLD_A) ? POS_HOLD_B : POS_HOLD_A;

    if (!last) return 1'b0;

    len      = int'(pos_q);
    rec_addr = '0;
    dbytes   = '0;
    win      = 1'b0;
    if (no_s_q) st = ST_NO_S;
    else if (len < int'(LEN_MIN)) st = ST_SHORT;
    else if (len % 2 != 0) st = ST_ODD;
    else if (bad_hex_q) st = ST_BAD_HEX;
    else if (len != int'(count_q) * 2 + 4) st = ST_COUNT;
    else if (sum_q != SUM_OK) st = ST_CHECKSUM;
    else begin
      case (type_q)
        RT_HEADER: begin
          if (len < int'(LEN_MIN_S0)) begin
            st = ST_BAD_S0;
          end else begin
            st = ST_OK;
            kinds_q[KIND_HEADER] = 1'b1;
          end
        end
        RT_DATA16, RT_DATA24: begin
          if ((len - 2) / 2 > MAX_RECORD_BYTES_DEF) begin
            st = ST_TOO_LONG;
          end else begin
            over     = (type_q == RT_DATA16) ? 3 : 4;
            st       = ST_OK;
            rec_addr = addr_q;
            dbytes   = (int'(count_q) > over) ? 8'(int'(count_q) - over) : 8'd0;
            win      = (rec_addr >= window_base);
            if (lines_q != LINES_MAX) lines_q = lines_q + 1'b1;
            kinds_q[KIND_DATA] = 1'b1;
          end
        end
        RT_COUNT: begin
          st = ST_OK;
          kinds_q[KIND_COUNT] = 1'b1;
        end
        RT_END24, RT_END16: begin
          st = ST_OK;
          kinds_q[KIND_END] = 1'b1;
        end
        default: st = ST_BAD_TYPE;
      endcase
    end

    res.status         = st;
    res.record_type    = type_q;
    res.record_address = rec_addr;
    res.data_bytes     = dbytes;
    res.in_window      = win;
    res.data_lines     = lines_q;
    res.types_seen     = kinds_q;
    res.file_complete  = ((kinds_q & needed_kinds) == needed_kinds);
    clear_line();
    return 1'b1;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (mismatches < 10) $display("line result %s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    line_result_t want;
    if (!rst_n) begin
      clear_line();
      kinds_q      = '0;
      lines_q      = '0;
      window_base  = '0;
      needed_kinds = REQ_TYPES_RESET;
      line_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (line_q.size() == 0) begin
          if (mismatches < 10) $display("line result with none expected, status %0d",
                                        out_mon.status);
          mismatches++;
        end else begin
          want = line_q.pop_front();
          compare_field("status", want.status, out_mon.status);
          compare_field("record_type", want.record_type, out_mon.record_type);
          compare_field("record_address", want.record_address, out_mon.record_address);
          compare_field("data_bytes", want.data_bytes, out_mon.data_bytes);
          compare_field("in_window", want.in_window, out_mon.in_window);
          compare_field("data_lines", want.data_lines, out_mon.data_lines);
          compare_field("types_seen", want.types_seen, out_mon.types_seen);
          compare_field("file_complete", want.file_complete, out_mon.file_complete);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_MIN_ADDRESS) window_base = cfg_pwdata[ADDR_W-1:0];
        else needed_kinds = cfg_pwdata[3:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        if (take_char(in_mon.char_code, in_mon.line_end, in_mon.file_start, want))
          line_q.push_back(want);
      end
    end
    pending_lines <= line_q.size();
  end

endmodule

// File: tb/tb_top.sv
// testbench top: clock, reset, character and register stimulus, result sink and verdict
`timescale 1ns / 100ps

module tb_top;
  import srec_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_CHARS   = 80;
  localparam int PHASES        = 5;
  localparam logic [7:0] HEX_EDGES [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  typedef logic [7:0] text_t[$];

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        pressure_on;
  int          mismatches;
  int          pending_lines;

  srec_in_if  in_ch ();
  srec_out_if out_ch ();

  srec_line_checker_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  srec_result_checker results (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .mismatches    (mismatches),
    .pending_lines (pending_lines)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic text_t encode_record(input logic [3:0] rtype, input text_t body,
                                          input int count_skew, input logic [7:0] sum_flip);
    text_t      t;
    logic [7:0] cnt;
    logic [7:0] sum;
    cnt = 8'(body.size() + 1 + count_skew);
    sum = cnt;
    foreach (body[i]) sum = sum + body[i];
    sum = ~sum ^ sum_flip;
    t.push_back(CHAR_S);
    t.push_back(hex_char(rtype));
    t.push_back(hex_char(cnt[7:4]));
    t.push_back(hex_char(cnt[3:0]));
    foreach (body[i]) begin
      t.push_back(hex_char(body[i][7:4]));
      t.push_back(hex_char(body[i][3:0]));
    end
    t.push_back(hex_char(sum[7:4]));
    t.push_back(hex_char(sum[3:0]));
    return t;
  endfunction

  function automatic text_t random_line();
    text_t      t;
    text_t      body;
    int         pick;
    int         r;
    int         n;
    int         n_addr;
    int         skew;
    int         fault;
    logic [7:0] flip;
    logic [3:0] rtype;
    pick = $urandom_range(0, 99);
    // junk characters over the whole byte range
    if (pick < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) t.push_back(8'($urandom));
      if ($urandom_range(0, 1)) t[0] = CHAR_S;
      return t;
    end
    case ($urandom_range(0, 9))
      0:       rtype = RT_HEADER;
      1, 2:    rtype = RT_DATA16;
      3, 4:    rtype = RT_DATA24;
      5:       rtype = RT_COUNT;
      6:       rtype = RT_END24;
      7:       rtype = RT_END16;
      default: rtype = 4'($urandom);
    endcase
    n_addr = (rtype == RT_DATA24 || rtype == RT_END24) ? 3 : 2;
    r = $urandom_range(0, 39);
    if (r < 2) n = $urandom_range(0, n_addr);
    else if (r < 4) n = $urandom_range(58, 68);
    else if (r == 4) n = $urandom_range(100, 254);
    else n = n_addr + $urandom_range(0, 16);
    repeat (n) body.push_back(8'($urandom));
    skew  = 0;
    flip  = '0;
    fault = (pick < 35) ? $urandom_range(0, 6) : -1;
    if (fault == 0) skew = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 2);
    if (fault == 1) flip = 8'(1 << $urandom_range(0, 7));
    t = encode_record(rtype, body, skew, flip);
    case (fault)
      2: t[0] = 8'($urandom);
      3: t.delete($urandom_range(1, t.size() - 1));
      4: begin
        if ($urandom_range(0, 1)) t[$urandom_range(1, t.size() - 1)] = 8'($urandom);
        else t[$urandom_range(1, t.size() - 1)] = HEX_EDGES[$urandom_range(0, 5)];
      end
      5: begin
        n = $urandom_range(1, 5);
        while (t.size() > n) void'(t.pop_back());
      end
      6: t[1] = 8'h47 + 8'($urandom_range(0, 19));
      default: ;
    endcase
    return t;
  endfunction

  function automatic text_t long_line(input int extra);
    text_t t;
    int    n;
    n = 2 * $urandom_range(513, 520) + extra;
    t.push_back(CHAR_S);
    t.push_back(hex_char(RT_DATA16));
    while (t.size() < n) t.push_back(hex_char(4'($urandom)));
    return t;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last, input logic fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.line_end   <= last;
    in_ch.file_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_line(input text_t t, input int fs_at);
    foreach (t[i]) send_char(t[i], i == t.size() - 1, i == fs_at);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_lines != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : receiver
    int hold_count;
    hold_count   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && hold_count < HOLD_CYCLES) begin
        hold_count++;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("srec_line_checker_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    text_t       line;
    int          budget;
    int          fs_at;
    int          r;
    logic [23:0] base_pick [PHASES];
    logic [3:0]  kinds_pick [PHASES];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.line_end   = 1'b0;
    in_ch.file_start = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    pressure_on      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_line(encode_record(RT_END16, '{8'h00, 8'h00}, 0, 8'h00), 0);
    line = '{8'h58};
    send_line(line, -1);
    send_line(encode_record(RT_DATA16, '{8'hFF, 8'hFF}, 0, 8'h00), -1);
    send_line(encode_record(RT_DATA24, '{8'hFF, 8'hFF, 8'hFF, 8'h00}, 0, 8'h00), -1);
    settle();

    base_pick  = '{24'h000000, 24'hFFFFFF, 24'($urandom), 24'($urandom_range(0, 16'hFFFF)),
                   24'h008000};
    kinds_pick = '{4'hF, 4'h0, 4'($urandom), REQ_TYPES_RESET, 4'($urandom)};
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_write(REG_MIN_ADDRESS, 32'(base_pick[ph]));
      cfg_write(REG_REQUIRED_TYPES, 32'(kinds_pick[ph]));
      case (ph)
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; pressure_on = 1'b1; end
        3:       begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      budget = 0;
      while (budget < PHASE_CHARS) begin
        line = random_line();
        r = $urandom_range(0, 99);
        if (r < 8) fs_at = 0;
        else if (r < 10) fs_at = $urandom_range(0, line.size() - 1);
        else fs_at = -1;
        send_line(line, fs_at);
        budget += line.size();
      end
      if (ph == 1) begin
        send_line(long_line($urandom_range(0, 1)), -1);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("srec_line_checker_unit verification clean");
    end else begin
      $display("srec_line_checker_unit verification failed");
    end
    $finish;
  end

endmodule

// File: srec_line_checker_unit.f
design/srec_pkg.sv
design/srec_if.sv
design/srec_chk_core.sv
design/srec_line_checker_unit.sv
tb/srec_result_checker.sv
tb/tb_top.sv
